// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clock, held off during reset
`define ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, clocked on clock, held off during reset
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/i2cee_pkg.sv =====
// Types and constants of the I2C EEPROM bit-level master
`default_nettype none

package i2cee_pkg;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_DATA  = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   localparam logic [2:0] CSR_DEVICE_ADDRESS = 3'd0;
   localparam logic [2:0] CSR_PAGE_SIZE_LOG2 = 3'd1;
   localparam logic [2:0] CSR_BIT_DELAY      = 3'd2;
   localparam logic [2:0] CSR_EDGE_DELAY     = 3'd3;
   localparam logic [2:0] CSR_WRITE_WAIT     = 3'd4;
   localparam logic [2:0] CSR_READ_WAIT      = 3'd5;

   localparam logic [6:0]  RST_DEVICE_ADDRESS = 7'd80;
   localparam logic [2:0]  RST_PAGE_SIZE_LOG2 = 3'd3;
   localparam logic [7:0]  RST_BIT_DELAY      = 8'd2;
   localparam logic [7:0]  RST_EDGE_DELAY     = 8'd5;
   localparam logic [15:0] RST_WRITE_WAIT     = 16'd500;
   localparam logic [15:0] RST_READ_WAIT      = 16'd200;

   typedef struct packed {
      logic [6:0]  device_address;
      logic [2:0]  page_size_log2;
      logic [7:0]  bit_delay_ticks;
      logic [7:0]  edge_delay_ticks;
      logic [15:0] write_wait_ticks;
      logic [15:0] read_wait_ticks;
   } cfg_type;

   typedef struct packed {
      logic       scl;
      logic       sda_release;
      logic       busy_res;
      logic       want_data;
      logic       rd_valid;
      logic [7:0] rd_data;
      logic       rd_last;
      logic       nack;
      logic       refused;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/i2c_eeprom_bitbang_master_top.sv =====
// Top level of the I2C EEPROM bit-level master: control registers and result register
`default_nettype none

// Bit-level I2C master for a byte-addressed EEPROM. Every accepted request word
// (a tick carrying the sampled SDA level, a write or read begin, or a write data
// byte) steps the bus sequencer once and yields exactly one result word, which
// appears on the rsp_ channel in the cycle after acceptance. One word is taken
// every clock cycle while rsp_ready is high; the sequencer steps once per word,
// and the result register holds the next word off while the last result waits.
// Control registers are written through csr_ with no wait and take effect at
// once; write them only while no transfer is running.

`include "assert_macros.svh"

module i2c_eeprom_bitbang_master_top #(
   parameter int ADDR_BITS   = 8,
   parameter int LENGTH_BITS = 16,
   parameter int DELAY_BITS  = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [7:0]  req_mem_addr,
   input  wire logic [15:0] req_length,
   input  wire logic [7:0]  req_wr_data,
   input  wire logic        req_sda_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_scl,
   output logic             rsp_sda_release,
   output logic             rsp_busy_res,
   output logic             rsp_want_data,
   output logic             rsp_rd_valid,
   output logic [7:0]       rsp_rd_data,
   output logic             rsp_rd_last,
   output logic             rsp_nack,
   output logic             rsp_refused,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import i2cee_pkg::*;

   cfg_type cfg_ff;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff;
   logic    accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   i2cee_core #(
      .ADDR_BITS   (ADDR_BITS),
      .LENGTH_BITS (LENGTH_BITS),
      .DELAY_BITS  (DELAY_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (accept),
      .cmd      (req_cmd),
      .mem_addr (req_mem_addr),
      .length   (req_length),
      .wr_data  (req_wr_data),
      .sda_in   (req_sda_in),
      .cfg      (cfg_ff),
      .result   (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address   <= RST_DEVICE_ADDRESS;
         cfg_ff.page_size_log2   <= RST_PAGE_SIZE_LOG2;
         cfg_ff.bit_delay_ticks  <= RST_BIT_DELAY;
         cfg_ff.edge_delay_ticks <= RST_EDGE_DELAY;
         cfg_ff.write_wait_ticks <= RST_WRITE_WAIT;
         cfg_ff.read_wait_ticks  <= RST_READ_WAIT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEVICE_ADDRESS: cfg_ff.device_address   <= csr_wdata[6:0];
            CSR_PAGE_SIZE_LOG2: cfg_ff.page_size_log2   <= csr_wdata[2:0];
            CSR_BIT_DELAY:      cfg_ff.bit_delay_ticks  <= csr_wdata[7:0];
            CSR_EDGE_DELAY:     cfg_ff.edge_delay_ticks <= csr_wdata[7:0];
            CSR_WRITE_WAIT:     cfg_ff.write_wait_ticks <= csr_wdata;
            CSR_READ_WAIT:      cfg_ff.read_wait_ticks  <= csr_wdata;
            default:            cfg_ff <= cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_scl         = rsp_ff.scl;
   assign rsp_sda_release = rsp_ff.sda_release;
   assign rsp_busy_res    = rsp_ff.busy_res;
   assign rsp_want_data   = rsp_ff.want_data;
   assign rsp_rd_valid    = rsp_ff.rd_valid;
   assign rsp_rd_data     = rsp_ff.rd_data;
   assign rsp_rd_last     = rsp_ff.rd_last;
   assign rsp_nack        = rsp_ff.nack;
   assign rsp_refused     = rsp_ff.refused;

   `ASSERT_NEXT(a_accept_gives_word, accept, rsp_valid_ff)
   `ASSERT_IMPL(a_rd_byte_busy, rsp_valid_ff && rsp_ff.rd_valid, rsp_ff.busy_res && !rsp_ff.refused)
   `ASSERT_IMPL(a_last_needs_byte, rsp_valid_ff && rsp_ff.rd_last, rsp_ff.rd_valid)
   `ASSERT_IMPL(a_want_holds_scl_low, rsp_valid_ff && rsp_ff.want_data, rsp_ff.busy_res && !rsp_ff.scl && rsp_ff.sda_release)

endmodule

`default_nettype wire

// ===== hw/rtl/i2cee_core.sv =====
// Bus sequencer: state registers and one-word step logic of the I2C master
`default_nettype none

module i2cee_core #(
   parameter int ADDR_BITS   = 8,
   parameter int LENGTH_BITS = 16,
   parameter int DELAY_BITS  = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [1:0]        cmd,
   input  wire logic [7:0]        mem_addr,
   input  wire logic [15:0]       length,
   input  wire logic [7:0]        wr_data,
   input  wire logic              sda_in,
   input  wire i2cee_pkg::cfg_type cfg,
   output i2cee_pkg::rsp_type     result
);
   import i2cee_pkg::*;

   typedef enum logic [3:0] {
      P_IDLE, P_START1, P_START2, P_TX_SETUP, P_TX_HIGH, P_TX_LOW, P_ACK, P_WANT,
      P_RX_LOW, P_RX_HIGH, P_RXACK_LOW, P_RXACK_HIGH, P_STOP1, P_STOP2, P_STOP3,
      P_WAIT
   } phase_type;

   typedef enum logic [1:0] {
      R_DEVW, R_MEM, R_DATA, R_DEVR
   } role_type;

   localparam logic [DELAY_BITS-1:0] DELAY_MAX = '1;

   phase_type               phase_ff, phase_in;
   role_type                role_ff, role_in;
   logic [3:0]              bit_index_ff, bit_index_in;
   logic [7:0]              shift_ff, shift_in;
   logic [ADDR_BITS-1:0]    addr_ff, addr_in;
   logic [LENGTH_BITS-1:0]  left_ff, left_in;
   logic [7:0]              page_left_ff, page_left_in;
   logic [DELAY_BITS-1:0]   delay_ff, delay_in;
   logic                    scl_ff, scl_in;
   logic                    sda_ff, sda_in_lvl;
   logic                    reading_ff, reading_in;
   logic                    nack_ff, nack_in;
   logic                    o_valid, o_last, refused;
   logic [7:0]              o_data;

   cmd_type                 cmd_c;
   logic [ADDR_BITS-1:0]    req_addr, page_addr, addr_inc;
   logic [LENGTH_BITS-1:0]  req_len, page_len, left_dec;
   logic [7:0]              page_size, page_low, chunk, page_bytes, page_dec;
   logic [7:0]              shift_tx, shift_rx;
   logic [3:0]              bit_next;
   logic [DELAY_BITS-1:0]   d_bit, d_edge, d_wwait, d_rwait;

   function automatic logic [DELAY_BITS-1:0] sat_ticks(input logic [15:0] t);
      logic [32:0] wide;
      wide = 33'(t);
      return (wide > 33'(DELAY_MAX)) ? DELAY_MAX : DELAY_BITS'(t);
   endfunction

   assign cmd_c    = cmd_type'(cmd);
   assign req_addr = ADDR_BITS'(mem_addr);
   assign req_len  = LENGTH_BITS'(length);
   assign addr_inc = addr_ff + ADDR_BITS'(1);
   assign left_dec = (left_ff != '0) ? left_ff - LENGTH_BITS'(1) : left_ff;
   assign page_dec = (page_left_ff != 8'd0) ? page_left_ff - 8'd1 : page_left_ff;
   assign shift_tx = {shift_ff[6:0], 1'b0};
   assign shift_rx = {shift_ff[6:0], sda_in};
   assign bit_next = bit_index_ff + 4'd1;

   assign page_addr  = (cmd_c == CMD_TICK) ? addr_ff : req_addr;
   assign page_len   = (cmd_c == CMD_TICK) ? left_ff : req_len;
   assign page_size  = 8'd1 << cfg.page_size_log2;
   assign page_low   = 8'(page_addr) & (page_size - 8'd1);
   assign chunk      = page_size - page_low;
   assign page_bytes = (LENGTH_BITS'(chunk) > page_len) ? 8'(page_len) : chunk;

   assign d_bit   = sat_ticks(16'(cfg.bit_delay_ticks));
   assign d_edge  = sat_ticks(16'(cfg.edge_delay_ticks));
   assign d_wwait = sat_ticks(cfg.write_wait_ticks);
   assign d_rwait = sat_ticks(cfg.read_wait_ticks);

   always_comb begin
      phase_in     = phase_ff;
      role_in      = role_ff;
      bit_index_in = bit_index_ff;
      shift_in     = shift_ff;
      addr_in      = addr_ff;
      left_in      = left_ff;
      page_left_in = page_left_ff;
      delay_in     = delay_ff;
      scl_in       = scl_ff;
      sda_in_lvl   = sda_ff;
      reading_in   = reading_ff;
      nack_in      = nack_ff;
      o_valid      = 1'b0;
      o_data       = 8'd0;
      o_last       = 1'b0;
      refused      = 1'b0;
      case (cmd_c)
         CMD_TICK: begin
            if (phase_ff != P_IDLE && phase_ff != P_WANT) begin
               if (delay_ff > DELAY_BITS'(1)) begin
                  delay_in = delay_ff - DELAY_BITS'(1);
               end else begin
                  case (phase_ff)
                     P_START1: begin
                        phase_in = P_START2; scl_in = 1'b1; sda_in_lvl = 1'b0;
                        delay_in = d_edge;
                     end
                     P_START2: begin
                        shift_in     = {cfg.device_address, role_ff == R_DEVR};
                        bit_index_in = 4'd0;
                        phase_in = P_TX_SETUP; scl_in = 1'b0;
                        sda_in_lvl = cfg.device_address[6]; delay_in = d_bit;
                     end
                     P_TX_SETUP: begin
                        phase_in = P_TX_HIGH; scl_in = 1'b1; delay_in = d_bit;
                     end
                     P_TX_HIGH: begin
                        phase_in = P_TX_LOW; scl_in = 1'b0; delay_in = d_bit;
                     end
                     P_TX_LOW: begin
                        shift_in     = shift_tx;
                        bit_index_in = bit_next;
                        delay_in     = d_bit;
                        if (bit_next < 4'd8) begin
                           phase_in = P_TX_SETUP; scl_in = 1'b0; sda_in_lvl = shift_tx[7];
                        end else begin
                           phase_in = P_ACK; scl_in = 1'b1; sda_in_lvl = 1'b1;
                        end
                     end
                     P_ACK: begin
                        nack_in = sda_in;
                        case (role_ff)
                           R_DEVW: begin
                              role_in      = R_MEM;
                              shift_in     = 8'(addr_ff);
                              bit_index_in = 4'd0;
                              phase_in = P_TX_SETUP; scl_in = 1'b0;
                              sda_in_lvl = shift_in[7]; delay_in = d_bit;
                           end
                           R_MEM: begin
                              if (reading_ff) begin
                                 role_in  = R_DEVR;
                                 phase_in = P_START1; scl_in = 1'b1; sda_in_lvl = 1'b1;
                                 delay_in = d_edge;
                              end else if (page_left_ff != 8'd0) begin
                                 role_in  = R_DATA;
                                 phase_in = P_WANT; scl_in = 1'b0; sda_in_lvl = 1'b1;
                                 delay_in = '0;
                              end else begin
                                 phase_in = P_STOP1; scl_in = 1'b0; sda_in_lvl = 1'b0;
                                 delay_in = d_edge;
                              end
                           end
                           R_DATA: begin
                              page_left_in = page_dec;
                              left_in      = left_dec;
                              addr_in      = addr_inc;
                              if (page_dec != 8'd0) begin
                                 phase_in = P_WANT; scl_in = 1'b0; sda_in_lvl = 1'b1;
                                 delay_in = '0;
                              end else begin
                                 phase_in = P_STOP1; scl_in = 1'b0; sda_in_lvl = 1'b0;
                                 delay_in = d_edge;
                              end
                           end
                           default: begin
                              bit_index_in = 4'd0;
                              shift_in     = 8'd0;
                              phase_in = P_RX_LOW; scl_in = 1'b0; sda_in_lvl = 1'b1;
                              delay_in = d_bit;
                           end
                        endcase
                     end
                     P_RX_LOW: begin
                        phase_in = P_RX_HIGH; scl_in = 1'b1; sda_in_lvl = 1'b1;
                        delay_in = d_bit;
                     end
                     P_RX_HIGH: begin
                        shift_in     = shift_rx;
                        bit_index_in = bit_next;
                        delay_in     = d_bit;
                        scl_in       = 1'b0;
                        if (bit_next < 4'd8) begin
                           phase_in = P_RX_LOW; sda_in_lvl = 1'b1;
                        end else begin
                           phase_in   = P_RXACK_LOW;
                           sda_in_lvl = !(left_ff > LENGTH_BITS'(1));
                        end
                     end
                     P_RXACK_LOW: begin
                        phase_in = P_RXACK_HIGH; scl_in = 1'b1; delay_in = d_bit;
                     end
                     P_RXACK_HIGH: begin
                        left_in = left_dec;
                        addr_in = addr_inc;
                        o_valid = 1'b1;
                        o_data  = shift_ff;
                        o_last  = (left_dec == '0);
                        if (left_dec != '0) begin
                           bit_index_in = 4'd0;
                           shift_in     = 8'd0;
                           phase_in = P_RX_LOW; scl_in = 1'b0; sda_in_lvl = 1'b1;
                           delay_in = d_bit;
                        end else begin
                           phase_in = P_STOP1; scl_in = 1'b0; sda_in_lvl = 1'b0;
                           delay_in = d_edge;
                        end
                     end
                     P_STOP1: begin
                        phase_in = P_STOP2; scl_in = 1'b1; sda_in_lvl = 1'b0;
                        delay_in = d_edge;
                     end
                     P_STOP2: begin
                        phase_in = P_STOP3; scl_in = 1'b1; sda_in_lvl = 1'b1;
                        delay_in = d_edge;
                     end
                     P_STOP3: begin
                        phase_in = P_WAIT; scl_in = 1'b1; sda_in_lvl = 1'b1;
                        delay_in = reading_ff ? d_rwait : d_wwait;
                     end
                     P_WAIT: begin
                        if (!reading_ff && left_ff != '0) begin
                           page_left_in = page_bytes;
                           role_in  = R_DEVW;
                           phase_in = P_START1; scl_in = 1'b1; sda_in_lvl = 1'b1;
                           delay_in = d_edge;
                        end else begin
                           phase_in = P_IDLE; scl_in = 1'b1; sda_in_lvl = 1'b1;
                           delay_in = '0;
                        end
                     end
                     default: begin
                        phase_in = phase_ff;
                     end
                  endcase
               end
            end
         end
         CMD_DATA: begin
            if (phase_ff == P_WANT) begin
               shift_in     = wr_data;
               bit_index_in = 4'd0;
               phase_in = P_TX_SETUP; scl_in = 1'b0; sda_in_lvl = wr_data[7];
               delay_in = d_bit;
            end else begin
               refused = 1'b1;
            end
         end
         default: begin
            if (phase_ff != P_IDLE || req_len == '0) begin
               refused = 1'b1;
            end else begin
               addr_in  = req_addr;
               left_in  = req_len;
               role_in  = R_DEVW;
               phase_in = P_START1; scl_in = 1'b1; sda_in_lvl = 1'b1;
               delay_in = d_edge;
               if (cmd_c == CMD_WRITE) begin
                  reading_in   = 1'b0;
                  page_left_in = page_bytes;
               end else begin
                  reading_in = 1'b1;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= P_IDLE;
         role_ff      <= R_DEVW;
         bit_index_ff <= 4'd0;
         shift_ff     <= 8'd0;
         addr_ff      <= '0;
         left_ff      <= '0;
         page_left_ff <= 8'd0;
         delay_ff     <= '0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         reading_ff   <= 1'b0;
         nack_ff      <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         role_ff      <= role_in;
         bit_index_ff <= bit_index_in;
         shift_ff     <= shift_in;
         addr_ff      <= addr_in;
         left_ff      <= left_in;
         page_left_ff <= page_left_in;
         delay_ff     <= delay_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in_lvl;
         reading_ff   <= reading_in;
         nack_ff      <= nack_in;
      end
   end

   always_comb begin
      result.scl         = scl_in;
      result.sda_release = sda_in_lvl;
      result.busy_res    = (phase_in != P_IDLE);
      result.want_data   = (phase_in == P_WANT);
      result.rd_valid    = o_valid;
      result.rd_data     = o_data;
      result.rd_last     = o_last;
      result.nack        = nack_in;
      result.refused     = refused;
   end

endmodule

`default_nettype wire

// ===== tb/tb_i2c_eeprom_bitbang_master_top.sv =====
// Self-checking testbench for the I2C EEPROM bit-level master, with its own sequencer predictor
`timescale 1ns / 100ps

module tb_i2c_eeprom_bitbang_master_top;
   import i2cee_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_AT     = 700;
   localparam int HOLD_CYCLES = 400;
   localparam int REPORT_MAX  = 10;

   typedef enum logic [4:0] {
      SEQ_IDLE, SEQ_START1, SEQ_START2, SEQ_TX_SETUP, SEQ_TX_HIGH, SEQ_TX_LOW,
      SEQ_ACK, SEQ_WANT, SEQ_RX_LOW, SEQ_RX_HIGH, SEQ_RXACK_LOW, SEQ_RXACK_HIGH,
      SEQ_STOP1, SEQ_STOP2, SEQ_STOP3, SEQ_WAIT
   } seq_phase_e;

   typedef enum logic [1:0] {
      BYTE_DEVW, BYTE_MEM, BYTE_DATA, BYTE_DEVR
   } byte_role_e;

   typedef struct packed {
      seq_phase_e  phase;
      byte_role_e  role;
      logic [3:0]  bit_index;
      logic [7:0]  shifter;
      logic [7:0]  addr;
      logic [15:0] bytes_left;
      logic [7:0]  page_left;
      logic [15:0] delay;
      logic        scl;
      logic        sda;
      logic        reading;
      logic        nack;
   } bus_state_t;

   typedef struct packed {
      cmd_type     cmd;
      logic [7:0]  mem_addr;
      logic [15:0] length;
      logic [7:0]  wr_data;
      logic        sda_in;
   } req_word_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = CMD_TICK;
   logic [7:0]  req_mem_addr = '0;
   logic [15:0] req_length = '0;
   logic [7:0]  req_wr_data = '0;
   logic        req_sda_in = 1'b1;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_scl, rsp_sda_release, rsp_busy_res, rsp_want_data;
   logic        rsp_rd_valid, rsp_rd_last, rsp_nack, rsp_refused;
   logic [7:0]  rsp_rd_data;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = CSR_DEVICE_ADDRESS;
   logic [15:0] csr_wdata = '0;

   cfg_type    cfg_now;
   bus_state_t chk_state, gen_state;
   req_word_t  pending[$];
   req_word_t  on_bus;
   rsp_type    expected[$];
   rsp_type    got_word, want_word;
   int         faults = 0;
   int         words_seen = 0;
   int         hold_left = 0;
   int         idle_run = 0;
   int         cyc = 0;
   logic       steady;

   assign steady = cyc >= 3000 && cyc < 7000;

   i2c_eeprom_bitbang_master_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_mem_addr(req_mem_addr), .req_length(req_length),
      .req_wr_data(req_wr_data), .req_sda_in(req_sda_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_scl(rsp_scl),
      .rsp_sda_release(rsp_sda_release), .rsp_busy_res(rsp_busy_res),
      .rsp_want_data(rsp_want_data), .rsp_rd_valid(rsp_rd_valid),
      .rsp_rd_data(rsp_rd_data), .rsp_rd_last(rsp_rd_last), .rsp_nack(rsp_nack),
      .rsp_refused(rsp_refused),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void bus_reset(inout bus_state_t s);
      s = '0;
      s.phase = SEQ_IDLE;
      s.role = BYTE_DEVW;
      s.scl = 1'b1;
      s.sda = 1'b1;
   endfunction

   function automatic void bus_enter(inout bus_state_t s, input seq_phase_e p,
                                     input logic c, input logic d, input logic [15:0] ticks);
      s.phase = p;
      s.scl = c;
      s.sda = d;
      s.delay = ticks;
   endfunction

   function automatic void page_open(inout bus_state_t s);
      int unsigned size, chunk;
      size = 1 << cfg_now.page_size_log2;
      chunk = size - (s.addr & (size - 1));
      if (chunk > s.bytes_left) chunk = s.bytes_left;
      s.page_left = chunk[7:0];
      s.role = BYTE_DEVW;
      bus_enter(s, SEQ_START1, 1'b1, 1'b1, cfg_now.edge_delay_ticks);
   endfunction

   function automatic void byte_send_first(inout bus_state_t s);
      s.bit_index = '0;
      bus_enter(s, SEQ_TX_SETUP, 1'b0, s.shifter[7], cfg_now.bit_delay_ticks);
   endfunction

   function automatic void byte_receive_open(inout bus_state_t s);
      s.bit_index = '0;
      s.shifter = '0;
      bus_enter(s, SEQ_RX_LOW, 1'b0, 1'b1, cfg_now.bit_delay_ticks);
   endfunction

   // advance the bus sequencer by one word and return the line and status word
   function automatic rsp_type bus_step(inout bus_state_t s, input req_word_t w);
      rsp_type r;
      r = '0;
      case (w.cmd)
         CMD_TICK: begin
            if (s.phase != SEQ_IDLE && s.phase != SEQ_WANT) begin
               if (s.delay > 16'd1) begin
                  s.delay = s.delay - 16'd1;
               end else begin
                  case (s.phase)
                     SEQ_START1: bus_enter(s, SEQ_START2, 1'b1, 1'b0, cfg_now.edge_delay_ticks);
                     SEQ_START2: begin
                        s.shifter = {cfg_now.device_address, s.role == BYTE_DEVR};
                        byte_send_first(s);
                     end
                     SEQ_TX_SETUP: bus_enter(s, SEQ_TX_HIGH, 1'b1, s.sda, cfg_now.bit_delay_ticks);
                     SEQ_TX_HIGH: bus_enter(s, SEQ_TX_LOW, 1'b0, s.sda, cfg_now.bit_delay_ticks);
                     SEQ_TX_LOW: begin
                        s.shifter = {s.shifter[6:0], 1'b0};
                        s.bit_index = s.bit_index + 4'd1;
                        if (s.bit_index < 4'd8)
                           bus_enter(s, SEQ_TX_SETUP, 1'b0, s.shifter[7], cfg_now.bit_delay_ticks);
                        else
                           bus_enter(s, SEQ_ACK, 1'b1, 1'b1, cfg_now.bit_delay_ticks);
                     end
                     SEQ_ACK: begin
                        s.nack = w.sda_in;
                        s.scl = 1'b0;
                        case (s.role)
                           BYTE_DEVW: begin
                              s.role = BYTE_MEM;
                              s.shifter = s.addr;
                              byte_send_first(s);
                           end
                           BYTE_MEM: begin
                              if (s.reading) begin
                                 s.role = BYTE_DEVR;
                                 bus_enter(s, SEQ_START1, 1'b1, 1'b1, cfg_now.edge_delay_ticks);
                              end else if (s.page_left != 0) begin
                                 s.role = BYTE_DATA;
                                 bus_enter(s, SEQ_WANT, 1'b0, 1'b1, 16'd0);
                              end else begin
                                 bus_enter(s, SEQ_STOP1, 1'b0, 1'b0, cfg_now.edge_delay_ticks);
                              end
                           end
                           BYTE_DATA: begin
                              if (s.page_left != 0) s.page_left = s.page_left - 8'd1;
                              if (s.bytes_left != 0) s.bytes_left = s.bytes_left - 16'd1;
                              s.addr = s.addr + 8'd1;
                              if (s.page_left != 0)
                                 bus_enter(s, SEQ_WANT, 1'b0, 1'b1, 16'd0);
                              else
                                 bus_enter(s, SEQ_STOP1, 1'b0, 1'b0, cfg_now.edge_delay_ticks);
                           end
                           default: byte_receive_open(s);
                        endcase
                     end
                     SEQ_RX_LOW: bus_enter(s, SEQ_RX_HIGH, 1'b1, 1'b1, cfg_now.bit_delay_ticks);
                     SEQ_RX_HIGH: begin
                        s.shifter = {s.shifter[6:0], w.sda_in};
                        s.bit_index = s.bit_index + 4'd1;
                        if (s.bit_index < 4'd8)
                           bus_enter(s, SEQ_RX_LOW, 1'b0, 1'b1, cfg_now.bit_delay_ticks);
                        else
                           bus_enter(s, SEQ_RXACK_LOW, 1'b0, !(s.bytes_left > 16'd1),
                                     cfg_now.bit_delay_ticks);
                     end
                     SEQ_RXACK_LOW: bus_enter(s, SEQ_RXACK_HIGH, 1'b1, s.sda, cfg_now.bit_delay_ticks);
                     SEQ_RXACK_HIGH: begin
                        if (s.bytes_left != 0) s.bytes_left = s.bytes_left - 16'd1;
                        s.addr = s.addr + 8'd1;
                        r.rd_valid = 1'b1;
                        r.rd_data = s.shifter;
                        r.rd_last = s.bytes_left == 0;
                        if (s.bytes_left != 0)
                           byte_receive_open(s);
                        else
                           bus_enter(s, SEQ_STOP1, 1'b0, 1'b0, cfg_now.edge_delay_ticks);
                     end
                     SEQ_STOP1: bus_enter(s, SEQ_STOP2, 1'b1, 1'b0, cfg_now.edge_delay_ticks);
                     SEQ_STOP2: bus_enter(s, SEQ_STOP3, 1'b1, 1'b1, cfg_now.edge_delay_ticks);
                     SEQ_STOP3: bus_enter(s, SEQ_WAIT, 1'b1, 1'b1,
                        s.reading ? cfg_now.read_wait_ticks : cfg_now.write_wait_ticks);
                     SEQ_WAIT: begin
                        if (!s.reading && s.bytes_left != 0)
                           page_open(s);
                        else
                           bus_enter(s, SEQ_IDLE, 1'b1, 1'b1, 16'd0);
                     end
                     default: ;
                  endcase
               end
            end
         end
         CMD_DATA: begin
            if (s.phase == SEQ_WANT) begin
               s.shifter = w.wr_data;
               byte_send_first(s);
            end else begin
               r.refused = 1'b1;
            end
         end
         default: begin
            if (s.phase != SEQ_IDLE || w.length == 0) begin
               r.refused = 1'b1;
            end else begin
               s.addr = w.mem_addr;
               s.bytes_left = w.length;
               if (w.cmd == CMD_WRITE) begin
                  s.reading = 1'b0;
                  page_open(s);
               end else begin
                  s.reading = 1'b1;
                  s.role = BYTE_DEVW;
                  bus_enter(s, SEQ_START1, 1'b1, 1'b1, cfg_now.edge_delay_ticks);
               end
            end
         end
      endcase
      r.scl = s.scl;
      r.sda_release = s.sda;
      r.busy_res = s.phase != SEQ_IDLE;
      r.want_data = s.phase == SEQ_WANT;
      r.nack = s.nack;
      return r;
   endfunction

   function automatic req_word_t make_word(input cmd_type c);
      req_word_t w;
      w.cmd = c;
      w.mem_addr = $urandom_range(255);
      w.length = $urandom_range(65535);
      w.wr_data = $urandom_range(255);
      w.sda_in = $urandom_range(1);
      return w;
   endfunction

   // track the sequencer ahead of the bus so that data words land when wanted
   function automatic void queue_word(input req_word_t w);
      void'(bus_step(gen_state, w));
      pending.push_back(w);
   endfunction

   function automatic void settle();
      while (gen_state.phase != SEQ_IDLE)
         queue_word(make_word(gen_state.phase == SEQ_WANT ? CMD_DATA : CMD_TICK));
   endfunction

   function automatic void one_transfer(input cmd_type c, input logic [7:0] a,
                                        input logic [15:0] n);
      req_word_t w;
      w = make_word(c);
      w.mem_addr = a;
      w.length = n;
      queue_word(w);
      settle();
   endfunction

   function automatic void run_random(input int budget, input int max_len);
      req_word_t w;
      int        roll;
      int        cap;
      cap = max_len < 12 ? max_len : 12;
      for (int n = 0; n < budget; n++) begin
         roll = $urandom_range(99);
         if (gen_state.phase == SEQ_IDLE) begin
            if (roll < 8) begin
               w = make_word($urandom_range(1) ? CMD_WRITE : CMD_READ);
               w.length = '0;
            end else if (roll < 14) begin
               w = make_word(CMD_DATA);
            end else if (roll < 18) begin
               w = make_word(CMD_TICK);
            end else begin
               w = make_word($urandom_range(1) ? CMD_WRITE : CMD_READ);
               if ($urandom_range(4) == 0) w.mem_addr = $urandom_range(255, 248);
               if ($urandom_range(9) == 0)
                  w.length = $urandom_range(max_len, 1);
               else
                  w.length = $urandom_range(cap, 1);
            end
         end else if (gen_state.phase == SEQ_WANT) begin
            if (roll < 85) w = make_word(CMD_DATA);
            else if (roll < 92) w = make_word(CMD_TICK);
            else w = make_word($urandom_range(1) ? CMD_WRITE : CMD_READ);
         end else begin
            if (roll < 94) w = make_word(CMD_TICK);
            else if (roll < 97) w = make_word(CMD_DATA);
            else w = make_word($urandom_range(1) ? CMD_WRITE : CMD_READ);
         end
         queue_word(w);
      end
      settle();
   endfunction

   task automatic csr_write(input logic [2:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_DEVICE_ADDRESS: cfg_now.device_address = val[6:0];
         CSR_PAGE_SIZE_LOG2: cfg_now.page_size_log2 = val[2:0];
         CSR_BIT_DELAY:      cfg_now.bit_delay_ticks = val[7:0];
         CSR_EDGE_DELAY:     cfg_now.edge_delay_ticks = val[7:0];
         CSR_WRITE_WAIT:     cfg_now.write_wait_ticks = val;
         CSR_READ_WAIT:      cfg_now.read_wait_ticks = val;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [6:0] dev, input logic [2:0] page,
                             input logic [7:0] bit_ticks, input logic [7:0] edge_ticks,
                             input logic [15:0] wr_wait, input logic [15:0] rd_wait);
      csr_write(CSR_DEVICE_ADDRESS, {9'd0, dev});
      csr_write(CSR_PAGE_SIZE_LOG2, {13'd0, page});
      csr_write(CSR_BIT_DELAY, {8'd0, bit_ticks});
      csr_write(CSR_EDGE_DELAY, {8'd0, edge_ticks});
      csr_write(CSR_WRITE_WAIT, wr_wait);
      csr_write(CSR_READ_WAIT, rd_wait);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending.size() != 0 || req_valid || expected.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // sender: hold the word until taken, then offer the next or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected.push_back(bus_step(chk_state, on_bus));
         if (!req_valid || req_ready) begin
            if (pending.size() != 0 && (steady || $urandom_range(99) >= 36)) begin
               on_bus = pending.pop_front();
               req_cmd <= on_bus.cmd;
               req_mem_addr <= on_bus.mem_addr;
               req_length <= on_bus.length;
               req_wr_data <= on_bus.wr_data;
               req_sda_in <= on_bus.sda_in;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: compare each result word with the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_word.scl = rsp_scl;
            got_word.sda_release = rsp_sda_release;
            got_word.busy_res = rsp_busy_res;
            got_word.want_data = rsp_want_data;
            got_word.rd_valid = rsp_rd_valid;
            got_word.rd_data = rsp_rd_data;
            got_word.rd_last = rsp_rd_last;
            got_word.nack = rsp_nack;
            got_word.refused = rsp_refused;
            if (expected.size() == 0) begin
               faults++;
               if (faults <= REPORT_MAX)
                  $display("unexpected result word %0d: %h", words_seen, got_word);
            end else begin
               want_word = expected.pop_front();
               if (got_word.scl !== want_word.scl
                   || got_word.sda_release !== want_word.sda_release
                   || got_word.busy_res !== want_word.busy_res
                   || got_word.want_data !== want_word.want_data
                   || got_word.rd_valid !== want_word.rd_valid
                   || got_word.rd_data !== want_word.rd_data
                   || got_word.rd_last !== want_word.rd_last
                   || got_word.nack !== want_word.nack
                   || got_word.refused !== want_word.refused) begin
                  faults++;
                  if (faults <= REPORT_MAX)
                     $display({"mismatch at word %0d: exp scl=%b sda=%b busy=%b want=%b",
                               " rv=%b rd=%h last=%b nack=%b ref=%b, got scl=%b sda=%b",
                               " busy=%b want=%b rv=%b rd=%h last=%b nack=%b ref=%b"},
                              words_seen, want_word.scl, want_word.sda_release,
                              want_word.busy_res, want_word.want_data, want_word.rd_valid,
                              want_word.rd_data, want_word.rd_last, want_word.nack,
                              want_word.refused, got_word.scl, got_word.sda_release,
                              got_word.busy_res, got_word.want_data, got_word.rd_valid,
                              got_word.rd_data, got_word.rd_last, got_word.nack,
                              got_word.refused);
               end
            end
            words_seen++;
            if (words_seen == HOLD_AT) hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || $urandom_range(99) >= 36;
         end
      end
   end

   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_run <= 0;
      end else if (idle_run >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_run <= idle_run + 1;
      end
   end

   initial begin
      req_word_t w;
      cfg_now.device_address = RST_DEVICE_ADDRESS;
      cfg_now.page_size_log2 = RST_PAGE_SIZE_LOG2;
      cfg_now.bit_delay_ticks = RST_BIT_DELAY;
      cfg_now.edge_delay_ticks = RST_EDGE_DELAY;
      cfg_now.write_wait_ticks = RST_WRITE_WAIT;
      cfg_now.read_wait_ticks = RST_READ_WAIT;
      bus_reset(chk_state);
      bus_reset(gen_state);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      w = make_word(CMD_TICK);
      w.sda_in = 1'b0;
      queue_word(w);
      w = make_word(CMD_TICK);
      w.sda_in = 1'b1;
      queue_word(w);
      w = make_word(CMD_WRITE);
      w.length = '0;
      queue_word(w);
      w = make_word(CMD_READ);
      w.length = '0;
      queue_word(w);
      queue_word(make_word(CMD_DATA));
      // page split across the address wrap, with refused words while busy
      w = make_word(CMD_WRITE);
      w.mem_addr = 8'hFE;
      w.length = 16'd3;
      queue_word(w);
      w = make_word(CMD_READ);
      w.length = 16'hFFFF;
      queue_word(w);
      queue_word(make_word(CMD_DATA));
      settle();
      one_transfer(CMD_READ, 8'hFF, 16'd2);
      one_transfer(CMD_READ, 8'h00, 16'd1);
      one_transfer(CMD_WRITE, 8'h00, 16'd1);
      run_random(200, 20);
      wait_drained();

      set_config(7'd0, 3'd0, 8'd1, 8'd1, 16'd0, 16'd0);
      run_random(400, 12);
      wait_drained();

      set_config(7'h7F, 3'd7, 8'd1, 8'd1, 16'd1, 16'd1);
      run_random(300, 300);
      wait_drained();

      set_config($urandom_range(127), 3'd2, 8'd3, 8'd2,
                 $urandom_range(40), $urandom_range(40));
      run_random(300, 10);
      wait_drained();

      set_config($urandom_range(127), 3'd5, 8'd255, 8'd255, 16'd0, 16'd0);
      one_transfer(CMD_WRITE, $urandom_range(255), 16'd1);
      one_transfer(CMD_READ, $urandom_range(255), 16'd1);
      wait_drained();

      set_config($urandom_range(127), 3'd4, 8'd1, 8'd1, 16'hFFFF, 16'hFFFF);
      one_transfer(CMD_WRITE, $urandom_range(255), 16'd2);
      one_transfer(CMD_READ, $urandom_range(255), 16'd2);
      wait_drained();

      set_config($urandom_range(127), 3'd1, 8'd2, 8'd3, 16'd8, 16'd8);
      run_random(300, 16);
      wait_drained();

      repeat (20) @(posedge clock);
      if (expected.size() != 0) faults++;
      if (faults == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== i2c_eeprom_bitbang_master_top.f =====
+incdir+hw/rtl
hw/rtl/i2cee_pkg.sv
hw/rtl/i2cee_core.sv
hw/rtl/i2c_eeprom_bitbang_master_top.sv
tb/tb_i2c_eeprom_bitbang_master_top.sv
